// ----- design/polyline_length_and_turning_unit_assert.svh -----
// Assertion macros for the polyline length and turning unit back end.
`ifndef POLYLINE_LENGTH_AND_TURNING_UNIT_ASSERT_SVH
`define POLYLINE_LENGTH_AND_TURNING_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define PLT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("plt assertion failed");
`define PLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("plt assertion failed");
`else
`define PLT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define PLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/plt_pkg.sv -----
`timescale 1ns / 1ps
// Package with the beat types, command type, state encodings and angle constants.
package plt_pkg;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [19:0] start_heading;
        logic signed [19:0] end_heading;
        logic               last_point;
    } point_t;

    typedef struct packed {
        logic [39:0] total_length;
        logic [31:0] total_turning;
    } total_t;

    // One classified point, handed from the front end to the back end.
    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic               has_seg;
        logic               need_head;
        logic               do_turn;
        logic               last;
        logic [20:0]        hterm;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_WORK,
        ST_WRAP,
        ST_ROUND,
        ST_ACCUM
    } back_state_t;

    typedef enum logic [1:0] {
        COR_NORM,
        COR_PRE,
        COR_ITER,
        COR_DONE
    } cor_phase_t;

    // Angles are scaled 2^30 per radian.
    localparam logic signed [34:0] ANG_HALF_PI = 35'sd1686629713;
    localparam logic signed [34:0] ANG_PI      = 35'sd3373259426;
    localparam logic signed [34:0] ANG_TWO_PI  = 35'sd6746518852;

    localparam logic [29:0] ATAN_TAB [0:31] = '{
        30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6,
        30'h03FEAB76, 30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55,
        30'h003FFFEA, 30'h001FFFFD, 30'h000FFFFF, 30'h0007FFFF,
        30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF, 30'h00007FFF,
        30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
        30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F,
        30'h0000003F, 30'h0000001F, 30'h0000000F, 30'h00000007,
        30'h00000003, 30'h00000001, 30'h00000000, 30'h00000000
    };

endpackage

// ----- design/plt_front.sv -----
`timescale 1ns / 1ps
// Front end: takes points, forms the segment delta and classifies the work it needs.
module plt_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            point_valid,
    output logic            point_ready,
    input  plt_pkg::point_t point,
    output logic            cmd_valid,
    input  logic            cmd_ready,
    output plt_pkg::cmd_t   cmd
);

    localparam logic [1:0] SEEN_NONE = 2'd0;
    localparam logic [1:0] SEEN_ONE  = 2'd1;
    localparam logic [1:0] SEEN_MORE = 2'd2;

    logic signed [31:0] prev_x_reg, prev_x_next;
    logic signed [31:0] prev_y_reg, prev_y_next;
    logic [1:0]         seen_reg, seen_next;
    logic               prev_zero_reg, prev_zero_next;
    logic               accept;
    logic               seg_zero;
    logic               has_seg;
    logic signed [20:0] hdiff;

    assign point_ready = cmd_ready;
    assign cmd_valid   = point_valid;
    assign accept      = point_valid && cmd_ready;

    always_comb
    begin
        cmd.dx   = $signed({point.point_x[31], point.point_x})
                 - $signed({prev_x_reg[31], prev_x_reg});
        cmd.dy   = $signed({point.point_y[31], point.point_y})
                 - $signed({prev_y_reg[31], prev_y_reg});
        seg_zero = (cmd.dx == '0) && (cmd.dy == '0);
        has_seg  = (seen_reg != SEEN_NONE);
        hdiff    = $signed({point.start_heading[19], point.start_heading})
                 - $signed({point.end_heading[19], point.end_heading});
        cmd.has_seg   = has_seg;
        cmd.need_head = has_seg && !seg_zero;
        cmd.do_turn   = (seen_reg == SEEN_MORE) && !seg_zero && !prev_zero_reg;
        cmd.last      = point.last_point;
        cmd.hterm     = hdiff[20] ? -hdiff : hdiff;
    end

    always_comb
    begin
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        seen_next      = seen_reg;
        prev_zero_next = prev_zero_reg;
        if (accept)
        begin
            if (point.last_point)
            begin
                // The path is closed: start the next one from a clean slate.
                prev_x_next    = '0;
                prev_y_next    = '0;
                seen_next      = SEEN_NONE;
                prev_zero_next = 1'b1;
            end
            else
            begin
                prev_x_next = point.point_x;
                prev_y_next = point.point_y;
                if (has_seg)
                begin
                    prev_zero_next = seg_zero;
                    seen_next      = SEEN_MORE;
                end
                else
                begin
                    seen_next = SEEN_ONE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            seen_reg      <= SEEN_NONE;
            prev_zero_reg <= 1'b1;
        end
        else
        begin
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            seen_reg      <= seen_next;
            prev_zero_reg <= prev_zero_next;
        end
    end

endmodule

// ----- design/plt_queue.sv -----
`timescale 1ns / 1ps
// Two-entry command queue between the front end and the back end.
module plt_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  plt_pkg::cmd_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output plt_pkg::cmd_t pop_data
);

    localparam int DEPTH = 2;
    localparam int PTR_W = 1;
    localparam int CNT_W = 2;

    plt_pkg::cmd_t    slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- design/plt_back.sv -----
`timescale 1ns / 1ps
// Back end: square root, CORDIC heading, turn wrap and saturating totals.
`include "polyline_length_and_turning_unit_assert.svh"
module plt_back #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 24
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  plt_pkg::cmd_t   cmd,
    output logic            total_valid,
    input  logic            total_ready,
    output plt_pkg::total_t total
);

    localparam int SQ_STEPS = 33;
    localparam int SQ_CNT_W = $clog2(SQ_STEPS + 1);
    localparam int CNT_W    = $clog2(CORDIC_STEPS);
    localparam int RSH      = 30 - FRAC_BITS;
    localparam int ANG_W    = 35;
    localparam logic [ANG_W-1:0] ROUND_HALF = ANG_W'(1) << (RSH - 1);

    plt_pkg::back_state_t state_reg, state_next;
    plt_pkg::cor_phase_t  cor_phase_reg, cor_phase_next;
    plt_pkg::cmd_t        cmd_reg, cmd_next;
    plt_pkg::total_t      out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;

    logic [CNT_W-1:0]    cor_cnt_reg, cor_cnt_next;
    logic [SQ_CNT_W-1:0] sq_cnt_reg, sq_cnt_next;
    logic [63:0]         prod_reg, prod_next;
    logic [65:0]         rad_reg, rad_next;
    logic [33:0]         root_reg, root_next;
    logic [35:0]         rem_reg, rem_next;
    logic [31:0]         ux_reg, ux_next;
    logic [31:0]         uy_reg, uy_next;
    logic [31:0]         m_reg, m_next;
    logic signed [ANG_W-1:0] cx_reg, cx_next;
    logic signed [ANG_W-1:0] cy_reg, cy_next;
    logic signed [ANG_W-1:0] cz_reg, cz_next;
    logic signed [ANG_W-1:0] prev_head_reg, prev_head_next;
    logic [ANG_W-1:0]    d_abs_reg, d_abs_next;
    logic [33:0]         len_add_reg, len_add_next;
    logic [ANG_W-1:0]    turn_add_reg, turn_add_next;
    logic [39:0]         length_sum_reg, length_sum_next;
    logic [31:0]         turning_sum_reg, turning_sum_next;

    logic        pop;
    logic        can_emit;
    logic        emit;
    logic        sq_done;
    logic        cor_done;
    logic        cor_run;
    logic [31:0] in_ax, in_ay, cur_ax, cur_ay, mul_op;
    logic [63:0] mul_res;
    logic [35:0] rem_shift, trial;
    logic signed [ANG_W-1:0] pre_x, pre_y, xs, ys, atan_val;
    logic signed [ANG_W-1:0] d_raw, d_w1, d_w2;
    logic [ANG_W:0]      rounded_wide;
    logic [40:0]         len_sum_wide;
    logic [ANG_W:0]      turn_sum_wide;
    logic [39:0]         len_sat;
    logic [31:0]         turn_sat;

    function automatic logic [31:0] mag33(input logic signed [32:0] v);
        logic signed [32:0] n;
        n = -v;
        return v[32] ? n[31:0] : v[31:0];
    endfunction

    assign sq_done  = (sq_cnt_reg == SQ_CNT_W'(SQ_STEPS));
    assign cor_done = (cor_phase_reg == plt_pkg::COR_DONE);
    assign can_emit = !out_valid_reg || total_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            plt_pkg::ST_IDLE:
                if (cmd_valid)
                begin
                    state_next = plt_pkg::ST_MUL_X;
                end
            plt_pkg::ST_MUL_X: state_next = plt_pkg::ST_MUL_Y;
            plt_pkg::ST_MUL_Y: state_next = plt_pkg::ST_WORK;
            plt_pkg::ST_WORK:
                if (sq_done && cor_done)
                begin
                    state_next = plt_pkg::ST_WRAP;
                end
            plt_pkg::ST_WRAP:  state_next = plt_pkg::ST_ROUND;
            plt_pkg::ST_ROUND: state_next = plt_pkg::ST_ACCUM;
            plt_pkg::ST_ACCUM:
                if (!cmd_reg.last || can_emit)
                begin
                    state_next = plt_pkg::ST_IDLE;
                end
            default: state_next = plt_pkg::ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb
    begin
        cmd_ready = (state_reg == plt_pkg::ST_IDLE);
        cor_run   = (state_reg == plt_pkg::ST_MUL_X) || (state_reg == plt_pkg::ST_MUL_Y)
                 || (state_reg == plt_pkg::ST_WORK);
        pop       = cmd_valid && cmd_ready;
        emit      = (state_reg == plt_pkg::ST_ACCUM) && cmd_reg.last && can_emit;
    end

    // Datapath.
    always_comb
    begin
        cor_phase_next   = cor_phase_reg;
        cmd_next         = cmd_reg;
        cor_cnt_next     = cor_cnt_reg;
        sq_cnt_next      = sq_cnt_reg;
        prod_next        = prod_reg;
        rad_next         = rad_reg;
        root_next        = root_reg;
        rem_next         = rem_reg;
        ux_next          = ux_reg;
        uy_next          = uy_reg;
        m_next           = m_reg;
        cx_next          = cx_reg;
        cy_next          = cy_reg;
        cz_next          = cz_reg;
        prev_head_next   = prev_head_reg;
        d_abs_next       = d_abs_reg;
        len_add_next     = len_add_reg;
        turn_add_next    = turn_add_reg;
        length_sum_next  = length_sum_reg;
        turning_sum_next = turning_sum_reg;
        out_next         = out_reg;

        in_ax   = mag33(cmd.dx);
        in_ay   = mag33(cmd.dy);
        cur_ax  = mag33(cmd_reg.dx);
        cur_ay  = mag33(cmd_reg.dy);
        mul_op  = (state_reg == plt_pkg::ST_MUL_X) ? cur_ax : cur_ay;
        mul_res = mul_op * mul_op;

        rem_shift = {rem_reg[33:0], rad_reg[65:64]};
        trial     = {root_reg, 2'b01};

        pre_x    = cmd_reg.dx[32] ? -$signed({3'b000, ux_reg}) : $signed({3'b000, ux_reg});
        pre_y    = cmd_reg.dy[32] ? -$signed({3'b000, uy_reg}) : $signed({3'b000, uy_reg});
        xs       = cx_reg >>> cor_cnt_reg;
        ys       = cy_reg >>> cor_cnt_reg;
        atan_val = $signed({5'b00000, plt_pkg::ATAN_TAB[5'(cor_cnt_reg)]});

        d_raw = cz_reg - prev_head_reg;
        d_w1  = (d_raw > plt_pkg::ANG_PI) ? d_raw - plt_pkg::ANG_TWO_PI : d_raw;
        d_w2  = (d_w1 < -plt_pkg::ANG_PI) ? d_w1 + plt_pkg::ANG_TWO_PI : d_w1;

        rounded_wide  = ({1'b0, d_abs_reg} + {1'b0, ROUND_HALF}) >> RSH;
        len_sum_wide  = {1'b0, length_sum_reg} + {7'b0, len_add_reg};
        turn_sum_wide = {4'b0, turning_sum_reg} + {1'b0, turn_add_reg};
        len_sat       = len_sum_wide[40] ? '1 : len_sum_wide[39:0];
        turn_sat      = (turn_sum_wide[ANG_W:32] != '0) ? '1 : turn_sum_wide[31:0];

        unique case (state_reg)
            plt_pkg::ST_IDLE:
                if (pop)
                begin
                    cmd_next       = cmd;
                    ux_next        = in_ax;
                    uy_next        = in_ay;
                    m_next         = (in_ax > in_ay) ? in_ax : in_ay;
                    cor_phase_next = cmd.need_head ? plt_pkg::COR_NORM : plt_pkg::COR_DONE;
                    sq_cnt_next    = '0;
                    root_next      = '0;
                    rem_next       = '0;
                end
            plt_pkg::ST_MUL_X:
                prod_next = mul_res;
            plt_pkg::ST_MUL_Y:
                rad_next = {2'b00, prod_reg} + {2'b00, mul_res};
            plt_pkg::ST_WORK:
                if (!sq_done)
                begin
                    // One root bit per cycle, most significant pair first.
                    rad_next    = {rad_reg[63:0], 2'b00};
                    sq_cnt_next = sq_cnt_reg + 1'b1;
                    if (rem_shift >= trial)
                    begin
                        rem_next  = rem_shift - trial;
                        root_next = {root_reg[32:0], 1'b1};
                    end
                    else
                    begin
                        rem_next  = rem_shift;
                        root_next = {root_reg[32:0], 1'b0};
                    end
                end
            plt_pkg::ST_WRAP:
            begin
                d_abs_next   = d_w2[ANG_W-1] ? -d_w2 : d_w2;
                len_add_next = cmd_reg.has_seg
                             ? root_reg + 34'(rem_reg > {2'b00, root_reg}) : '0;
                if (cmd_reg.need_head)
                begin
                    prev_head_next = cz_reg;
                end
            end
            plt_pkg::ST_ROUND:
                turn_add_next = (cmd_reg.do_turn ? rounded_wide[ANG_W-1:0] : '0)
                              + (cmd_reg.last ? {14'b0, cmd_reg.hterm} : '0);
            plt_pkg::ST_ACCUM:
                if (!cmd_reg.last)
                begin
                    length_sum_next  = len_sat;
                    turning_sum_next = turn_sat;
                end
                else if (can_emit)
                begin
                    out_next.total_length  = len_sat;
                    out_next.total_turning = turn_sat;
                    length_sum_next        = '0;
                    turning_sum_next       = '0;
                end
            default:
            begin
            end
        endcase

        // The heading pass runs alongside the multiplies and the root.
        if (cor_run)
        begin
            unique case (cor_phase_reg)
                plt_pkg::COR_NORM:
                    if (m_reg[31])
                    begin
                        ux_next = ux_reg >> 1;
                        uy_next = uy_reg >> 1;
                        m_next  = m_reg >> 1;
                    end
                    else if (m_reg[30])
                    begin
                        cor_phase_next = plt_pkg::COR_PRE;
                    end
                    else if (m_reg[29:26] == '0)
                    begin
                        ux_next = ux_reg << 4;
                        uy_next = uy_reg << 4;
                        m_next  = m_reg << 4;
                    end
                    else
                    begin
                        ux_next = ux_reg << 1;
                        uy_next = uy_reg << 1;
                        m_next  = m_reg << 1;
                    end
                plt_pkg::COR_PRE:
                begin
                    cor_cnt_next   = '0;
                    cor_phase_next = plt_pkg::COR_ITER;
                    if (pre_x[ANG_W-1] && !pre_y[ANG_W-1])
                    begin
                        cx_next = pre_y;
                        cy_next = -pre_x;
                        cz_next = plt_pkg::ANG_HALF_PI;
                    end
                    else if (pre_x[ANG_W-1])
                    begin
                        cx_next = -pre_y;
                        cy_next = pre_x;
                        cz_next = -plt_pkg::ANG_HALF_PI;
                    end
                    else
                    begin
                        cx_next = pre_x;
                        cy_next = pre_y;
                        cz_next = '0;
                    end
                end
                plt_pkg::COR_ITER:
                begin
                    if (cy_reg > 0)
                    begin
                        cx_next = cx_reg + ys;
                        cy_next = cy_reg - xs;
                        cz_next = cz_reg + atan_val;
                    end
                    else
                    begin
                        cx_next = cx_reg - ys;
                        cy_next = cy_reg + xs;
                        cz_next = cz_reg - atan_val;
                    end
                    if (cor_cnt_reg == CNT_W'(CORDIC_STEPS - 1))
                    begin
                        cor_phase_next = plt_pkg::COR_DONE;
                    end
                    else
                    begin
                        cor_cnt_next = cor_cnt_reg + 1'b1;
                    end
                end
                plt_pkg::COR_DONE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (total_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign total_valid = out_valid_reg;
    assign total       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= plt_pkg::ST_IDLE;
            cor_phase_reg   <= plt_pkg::COR_DONE;
            cor_cnt_reg     <= '0;
            sq_cnt_reg      <= '0;
            out_valid_reg   <= 1'b0;
            length_sum_reg  <= '0;
            turning_sum_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            cor_phase_reg   <= cor_phase_next;
            cor_cnt_reg     <= cor_cnt_next;
            sq_cnt_reg      <= sq_cnt_next;
            out_valid_reg   <= out_valid_next;
            length_sum_reg  <= length_sum_next;
            turning_sum_reg <= turning_sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        out_reg       <= out_next;
        prod_reg      <= prod_next;
        rad_reg       <= rad_next;
        root_reg      <= root_next;
        rem_reg       <= rem_next;
        ux_reg        <= ux_next;
        uy_reg        <= uy_next;
        m_reg         <= m_next;
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        cz_reg        <= cz_next;
        prev_head_reg <= prev_head_next;
        d_abs_reg     <= d_abs_next;
        len_add_reg   <= len_add_next;
        turn_add_reg  <= turn_add_next;
    end

    `PLT_ASSERT_NEXT(a_emit_shows_total, clk, rst_n, emit, total_valid)
    `PLT_ASSERT_IMPL(a_sq_cnt_bound, clk, rst_n, 1'b1, sq_cnt_reg <= SQ_CNT_W'(SQ_STEPS))
    `PLT_ASSERT_IMPL(a_work_exit, clk, rst_n, state_reg == plt_pkg::ST_WORK && state_next != plt_pkg::ST_WORK, sq_done && cor_done)

endmodule

// ----- design/polyline_length_and_turning_unit.sv -----
`timescale 1ns / 1ps
// Top level of the polyline length and turning unit.
//
// Path points enter on the point channel (valid/ready), one beat per point, in
// signed Q16.16. Each point after the first closes a segment whose Euclidean
// length is added to a length total; from the second segment on, the angle
// between consecutive segments is added to a turning total. The beat marked
// last_point also adds |start_heading - end_heading| and produces one beat on
// the total channel carrying both totals; the unit then starts a fresh path.
// Both totals saturate at their field maximum.
//
// Back end schedule: it works on one point at a time and takes the next
// command only when idle. For each point it takes the command, runs two
// multiply steps and the square root (33 root bits plus the exit check),
// then wraps, rounds and accumulates. The heading pass (normalize, one
// quadrant step, CORDIC_STEPS steps) runs next to the multiplies and
// the root.
// The front end and a two-beat command queue take new points while the back
// end works, and the total sits in an output register, so a stalled receiver
// only holds the back end once a second total is ready.
// Reset clears the running totals, the stored point and all valid flags.
module polyline_length_and_turning_unit #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 24
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            point_valid,
    output logic            point_ready,
    input  plt_pkg::point_t point,
    output logic            total_valid,
    input  logic            total_ready,
    output plt_pkg::total_t total
);

    // Front end to queue.
    logic          fq_valid;
    logic          fq_ready;
    plt_pkg::cmd_t fq_cmd;

    // Queue to back end.
    logic          qb_valid;
    logic          qb_ready;
    plt_pkg::cmd_t qb_cmd;

    plt_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .point       (point),
        .cmd_valid   (fq_valid),
        .cmd_ready   (fq_ready),
        .cmd         (fq_cmd)
    );

    plt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_cmd),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_cmd)
    );

    plt_back #(
        .FRAC_BITS    (FRAC_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (qb_valid),
        .cmd_ready   (qb_ready),
        .cmd         (qb_cmd),
        .total_valid (total_valid),
        .total_ready (total_ready),
        .total       (total)
    );

endmodule
